// ===== rtl/core/u2c_pkg.sv =====
// Package for the UTF-8 to code page 437 converter.
// Holds the byte and beat types, the lead byte decoder and the code page table.
// No dependencies.
package u2c_pkg;

  localparam int CNT_W = 6;
  localparam int ACC_W = 32;
  localparam int BURST_MAX = 3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  is_end;
  } beat_t;

  typedef struct packed {
    beat_t [BURST_MAX-1:0] beat;
    logic  [1:0]           n;
  } burst_t;

  typedef struct packed {
    logic       can_load;
    logic [1:0] level;
  } obuf_status_t;

  function automatic logic [6:0] lead_value(input byte_t b);
    logic [6:0] v;
    logic       run;
    v   = b[6:0];
    run = b[7];
    for (int i = 6; i >= 0; i--) begin
      if (run && v[i]) begin
        v[i] = 1'b0;
      end else begin
        run = 1'b0;
      end
    end
    return v;
  endfunction

  function automatic byte_t cp437_map(input logic [ACC_W-1:0] cp);
    byte_t m;
    m = cp[7:0];
    if (cp[ACC_W-1:16] == '0) begin
      case (cp[15:0])
        16'h00C7: m = 8'h80; 16'h00FC: m = 8'h81; 16'h00E9: m = 8'h82; 16'h00E2: m = 8'h83;
        16'h00E4: m = 8'h84; 16'h00E0: m = 8'h85; 16'h00E5: m = 8'h86; 16'h00E7: m = 8'h87;
        16'h00EA: m = 8'h88; 16'h00EB: m = 8'h89; 16'h00E8: m = 8'h8A; 16'h00EF: m = 8'h8B;
        16'h00EE: m = 8'h8C; 16'h00EC: m = 8'h8D; 16'h00C4: m = 8'h8E; 16'h00C5: m = 8'h8F;
        16'h00C9: m = 8'h90; 16'h00E6: m = 8'h91; 16'h00C6: m = 8'h92; 16'h00F4: m = 8'h93;
        16'h00F6: m = 8'h94; 16'h00F2: m = 8'h95; 16'h00FB: m = 8'h96; 16'h00F9: m = 8'h97;
        16'h00FF: m = 8'h98; 16'h00D6: m = 8'h99; 16'h00DC: m = 8'h9A; 16'h00A2: m = 8'h9B;
        16'h00A3: m = 8'h9C; 16'h00A5: m = 8'h9D; 16'h20A7: m = 8'h9E; 16'h0192: m = 8'h9F;
        16'h00E1: m = 8'hA0; 16'h00ED: m = 8'hA1; 16'h00F3: m = 8'hA2; 16'h00FA: m = 8'hA3;
        16'h00F1: m = 8'hA4; 16'h00D1: m = 8'hA5; 16'h00AA: m = 8'hA6; 16'h00BA: m = 8'hA7;
        16'h00BF: m = 8'hA8; 16'h2310: m = 8'hA9; 16'h00AC: m = 8'hAA; 16'h00BD: m = 8'hAB;
        16'h00BC: m = 8'hAC; 16'h00A1: m = 8'hAD; 16'h00AB: m = 8'hAE; 16'h00BB: m = 8'hAF;
        16'h2591: m = 8'hB0; 16'h2592: m = 8'hB1; 16'h2593: m = 8'hB2; 16'h2502: m = 8'hB3;
        16'h2524: m = 8'hB4; 16'h2561: m = 8'hB5; 16'h2562: m = 8'hB6; 16'h2556: m = 8'hB7;
        16'h2555: m = 8'hB8; 16'h2563: m = 8'hB9; 16'h2551: m = 8'hBA; 16'h2557: m = 8'hBB;
        16'h255D: m = 8'hBC; 16'h255C: m = 8'hBD; 16'h255B: m = 8'hBE; 16'h2510: m = 8'hBF;
        16'h2514: m = 8'hC0; 16'h2534: m = 8'hC1; 16'h252C: m = 8'hC2; 16'h251C: m = 8'hC3;
        16'h2500: m = 8'hC4; 16'h253C: m = 8'hC5; 16'h255E: m = 8'hC6; 16'h255F: m = 8'hC7;
        16'h255A: m = 8'hC8; 16'h2554: m = 8'hC9; 16'h2569: m = 8'hCA; 16'h2566: m = 8'hCB;
        16'h2560: m = 8'hCC; 16'h2550: m = 8'hCD; 16'h256C: m = 8'hCE; 16'h2567: m = 8'hCF;
        16'h2568: m = 8'hD0; 16'h2564: m = 8'hD1; 16'h2565: m = 8'hD2; 16'h2559: m = 8'hD3;
        16'h2558: m = 8'hD4; 16'h2552: m = 8'hD5; 16'h2553: m = 8'hD6; 16'h256B: m = 8'hD7;
        16'h256A: m = 8'hD8; 16'h2518: m = 8'hD9; 16'h250C: m = 8'hDA; 16'h2588: m = 8'hDB;
        16'h2584: m = 8'hDC; 16'h258C: m = 8'hDD; 16'h2590: m = 8'hDE; 16'h2580: m = 8'hDF;
        16'h03B1: m = 8'hE0; 16'h00DF: m = 8'hE1; 16'h0393: m = 8'hE2; 16'h03C0: m = 8'hE3;
        16'h03A3: m = 8'hE4; 16'h03C3: m = 8'hE5; 16'h00B5: m = 8'hE6; 16'h03C4: m = 8'hE7;
        16'h03A6: m = 8'hE8; 16'h0398: m = 8'hE9; 16'h03A9: m = 8'hEA; 16'h03B4: m = 8'hEB;
        16'h221E: m = 8'hEC; 16'h03C6: m = 8'hED; 16'h03B5: m = 8'hEE; 16'h2229: m = 8'hEF;
        16'h2261: m = 8'hF0; 16'h00B1: m = 8'hF1; 16'h2265: m = 8'hF2; 16'h2264: m = 8'hF3;
        16'h2320: m = 8'hF4; 16'h2321: m = 8'hF5; 16'h00F7: m = 8'hF6; 16'h2248: m = 8'hF7;
        16'h00B0: m = 8'hF8; 16'h2219: m = 8'hF9; 16'h00B7: m = 8'hFA; 16'h221A: m = 8'hFB;
        16'h207F: m = 8'hFC; 16'h00B2: m = 8'hFD; 16'h25A0: m = 8'hFE; 16'h00A0: m = 8'hFF;
        default: m = cp[7:0];
      endcase
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/u2c_ifs.sv =====
// Valid/ready channel interfaces for the UTF-8 to code page 437 converter.
// Depends on u2c_pkg.
interface u2c_in_if;
  import u2c_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u2c_out_if;
  import u2c_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_end;
  modport source (output valid, output out_byte, output out_end, input ready);
  modport sink (input valid, input out_byte, input out_end, output ready);
endinterface

// ===== rtl/core/utf8_to_cp437_converter_top.sv =====
// Top level of the UTF-8 to code page 437 string converter.
// Depends on u2c_pkg, u2c_ifs, u2c_decode and u2c_outbuf.
//
// The input channel carries one UTF-8 byte per beat with a flag on the final byte
// of a string. The result channel carries code page 437 bytes, and every string is
// closed by a terminator beat with out_end set and a zero byte.
// An accepted byte yields zero, one, two or three result beats. They appear on the
// result channel from the cycle after acceptance, one per cycle while the receiver is ready.
// The input is ready while the three-entry result buffer is empty or is handing over
// its last beat, so a stream whose bytes yield at most one beat each runs at one byte
// per cycle while the receiver is ready; a byte yielding more beats holds the input
// until all but its last are handed over; a byte that yields none does not hold it.
// When the receiver stalls, the buffered beats hold and the input stops while the
// buffer holds any beat.
// At most MAX_CHARS decoded characters are sent per string; the rest are dropped.
// cfg_wr_en writes cfg_wr_data to the convert enable bit; with it clear, bytes pass
// through unchanged. Write it only while the block is idle.
// Reset clears the decoder state and the buffer and sets the convert enable bit.
module utf8_to_cp437_converter_top #(
  parameter int MAX_CHARS = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  u2c_in_if.sink    in_ch,
  u2c_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import u2c_pkg::*;

  logic         convert_en_r;
  logic         in_fire;
  burst_t       burst;
  beat_t        head;
  obuf_status_t status;
  logic [1:0]   last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      convert_en_r <= cfg_wr_data;
    end
  end

  assign in_ch.ready = status.can_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  u2c_decode #(
    .MAX_CHARS(MAX_CHARS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .convert_en(convert_en_r),
    .fire      (in_fire),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .burst     (burst)
  );

  u2c_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .burst    (burst),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .head     (head),
    .status   (status)
  );

  assign out_ch.out_byte = head.data;
  assign out_ch.out_end  = head.is_end;

  assign last_idx = burst.n - 2'd1;

  a_level_follows_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> status.level == $past(burst.n))
    else $error("result buffer level does not match the loaded burst");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.in_last |-> (burst.n != 2'd0) && burst.beat[last_idx].is_end)
    else $error("final byte did not produce a closing terminator beat");

  a_pass_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !convert_en_r && !in_ch.in_last |-> burst.n == 2'd1)
    else $error("pass-through byte did not produce exactly one beat");

endmodule

// ===== rtl/core/u2c_decode.sv =====
// Lenient UTF-8 decoder with code page 437 mapping, per-string character limit and a pass-through mode.
// Produces the ordered result beats for one accepted byte. Depends on u2c_pkg.
module u2c_decode #(
  parameter int MAX_CHARS = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            convert_en,
  input  logic            fire,
  input  u2c_pkg::byte_t  in_byte,
  input  logic            in_last,
  output u2c_pkg::burst_t burst
);
  import u2c_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_CHARS);

  logic [ACC_W-1:0] acc_r, acc_nxt, acc_mid;
  logic             pend_r, pend_nxt, pend_mid;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_mid;
  logic             cont;
  logic [2:0]       cand_v;
  beat_t [2:0]      cand;
  logic [1:0]       n;

  assign cont = (in_byte[7:6] == 2'b10) && pend_r;

  always_comb begin
    cand_v   = '0;
    cand     = '0;
    acc_mid  = acc_r;
    pend_mid = pend_r;
    cnt_mid  = cnt_r;
    if (!convert_en) begin
      cand_v[0]       = 1'b1;
      cand[0].data    = in_byte;
      acc_mid         = '0;
      pend_mid        = 1'b0;
    end else if (cont) begin
      acc_mid  = {acc_r[ACC_W-7:0], in_byte[5:0]};
      pend_mid = 1'b1;
    end else begin
      if (pend_r && (cnt_r < MaxCnt)) begin
        cand_v[0]    = 1'b1;
        cand[0].data = cp437_map(acc_r);
        cnt_mid      = cnt_r + 1'b1;
      end
      acc_mid  = {{(ACC_W-7){1'b0}}, lead_value(in_byte)};
      pend_mid = 1'b1;
    end

    if (in_last) begin
      if (pend_mid && (cnt_mid < MaxCnt)) begin
        cand_v[1]    = 1'b1;
        cand[1].data = cp437_map(acc_mid);
      end
      cand_v[2]       = 1'b1;
      cand[2].data    = '0;
      cand[2].is_end  = 1'b1;
      acc_nxt  = '0;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
    end else begin
      acc_nxt  = acc_mid;
      pend_nxt = pend_mid;
      cnt_nxt  = cnt_mid;
    end
  end

  always_comb begin
    burst = '0;
    n     = '0;
    for (int k = 0; k < BURST_MAX; k++) begin
      if (cand_v[k]) begin
        burst.beat[n] = cand[k];
        n = n + 1'b1;
      end
    end
    burst.n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else if (fire) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/u2c_outbuf.sv =====
// Result buffer holding up to three beats and draining one beat per cycle while out_ready is high.
// Depends on u2c_pkg.
module u2c_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  u2c_pkg::burst_t       burst,
  input  logic                  out_ready,
  output logic                  out_valid,
  output u2c_pkg::beat_t        head,
  output u2c_pkg::obuf_status_t status
);
  import u2c_pkg::*;

  beat_t [BURST_MAX-1:0] beats_r;
  logic [1:0]            level_r;
  logic                  pop;

  assign out_valid       = (level_r != 2'd0);
  assign head            = beats_r[0];
  assign pop             = out_valid && out_ready;
  assign status.level    = level_r;
  assign status.can_load = (level_r == 2'd0) || ((level_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      beats_r <= burst.beat;
    end else if (pop) begin
      beats_r[0] <= beats_r[1];
      beats_r[1] <= beats_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 2'd0;
    end else if (load) begin
      level_r <= burst.n;
    end else if (pop) begin
      level_r <= level_r - 2'd1;
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_cp437_converter_top: directed and random byte strings
// with random gaps on both channels, checked beat by beat against a built-in predictor.
// Depends on u2c_pkg, the u2c_ifs interfaces and the converter top level.
module testbench;
  import u2c_pkg::*;

  localparam int MAX_CHARS     = 50;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    byte_t b;
    logic  last;
    bit    drain;
    bit    calm;
  } in_item_t;

  // Code points of code page 437 bytes 0x80 to 0xFF, in byte order.
  logic [15:0] cp_tab [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;

  u2c_in_if  in_ch ();
  u2c_out_if out_ch ();

  utf8_to_cp437_converter_top #(
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bit          cvt_en    = 1'b1;
  logic [31:0] code_acc  = '0;
  bit          code_open = 1'b0;
  logic [5:0]  n_chars   = '0;

  in_item_t pending_bytes [$];
  beat_t    expected_beats [$];
  byte_t    str_bytes [$];

  bit calm_mode = 1'b0;
  bit in_taken  = 1'b0;
  int in_gap    = 0;
  int out_stall = 0;
  int n_err     = 0;
  int cycle_cnt = 0;

  function automatic byte_t cp437_of(logic [31:0] cp);
    for (int k = 0; k < 128; k++) begin
      if (cp == {16'h0000, cp_tab[k]}) return byte_t'(8'h80 + k);
    end
    return cp[7:0];
  endfunction

  function automatic logic [31:0] lead_start(byte_t b);
    logic [6:0] v;
    bit         clearing;
    if (!b[7]) return {24'h0, b};
    v        = b[6:0];
    clearing = 1'b1;
    for (int i = 6; i >= 0; i--) begin
      if (clearing && v[i]) v[i] = 1'b0;
      else clearing = 1'b0;
    end
    return {25'h0, v};
  endfunction

  task automatic push_beat(byte_t d, logic e);
    beat_t bt;
    bt.data   = d;
    bt.is_end = e;
    expected_beats.push_back(bt);
  endtask

  task automatic emit_char();
    if (n_chars < MAX_CHARS) begin
      push_beat(cp437_of(code_acc), 1'b0);
      n_chars++;
    end
  endtask

  task automatic predict_byte(byte_t b, logic last);
    if (!cvt_en) begin
      code_acc  = '0;
      code_open = 1'b0;
      push_beat(b, 1'b0);
    end else if (b[7:6] == 2'b10 && code_open) begin
      code_acc = {code_acc[25:0], b[5:0]};
    end else begin
      if (code_open) emit_char();
      code_acc  = lead_start(b);
      code_open = 1'b1;
    end
    if (last) begin
      if (code_open) emit_char();
      push_beat(8'h00, 1'b1);
      code_acc  = '0;
      code_open = 1'b0;
      n_chars   = '0;
    end
  endtask

  function automatic int idle_len();
    int r;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_byte(in_ch.in_byte, in_ch.in_last);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_in
    in_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_taken || !in_ch.valid) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_bytes.size() != 0 &&
                   (!pending_bytes[0].drain || expected_beats.size() == 0)) begin
        it        = pending_bytes.pop_front();
        calm_mode = it.calm;
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= it.b;
        in_ch.in_last <= it.last;
        in_gap = idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      out_stall = idle_len();
    end
  end

  always @(posedge clk) begin : check_out
    beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual byte %02h end %0b",
                 $time, out_ch.out_byte, out_ch.out_end);
        n_err++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.data, out_ch.out_byte);
          n_err++;
        end
        if (out_ch.out_end !== want.is_end) begin
          $display("%0t: out_end mismatch: expected %0b, actual %0b",
                   $time, want.is_end, out_ch.out_end);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic commit_string(bit calm, int drain_at);
    in_item_t it;
    foreach (str_bytes[i]) begin
      it.b     = str_bytes[i];
      it.last  = (i == str_bytes.size() - 1);
      it.drain = (i == drain_at);
      it.calm  = calm;
      pending_bytes.push_back(it);
    end
  endtask

  function automatic logic [31:0] random_cp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 127);
      4, 5, 6:    return {16'h0000, cp_tab[$urandom_range(0, 127)]};
      7:          return $urandom_range(32'h80, 32'h7FF);
      8:          return $urandom_range(32'h800, 32'hFFFF);
      default:    return $urandom_range(32'h10000, 32'h10FFFF);
    endcase
  endfunction

  task automatic put_char(logic [31:0] cp);
    if (cp < 32'h80) begin
      str_bytes.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      str_bytes.push_back(8'hC0 | cp[10:6]);
      str_bytes.push_back(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      str_bytes.push_back(8'hE0 | cp[15:12]);
      str_bytes.push_back(8'h80 | cp[11:6]);
      str_bytes.push_back(8'h80 | cp[5:0]);
    end else begin
      str_bytes.push_back(8'hF0 | cp[20:18]);
      str_bytes.push_back(8'h80 | cp[17:12]);
      str_bytes.push_back(8'h80 | cp[11:6]);
      str_bytes.push_back(8'h80 | cp[5:0]);
    end
  endtask

  // Mostly well-formed strings, some long enough to hit the character limit;
  // the rest is noise rich in continuation bytes.
  task automatic gen_string(input bit want_long, output int n);
    int len;
    str_bytes.delete();
    if (want_long || $urandom_range(0, 9) < 8) begin
      if (want_long || $urandom_range(0, 11) == 0) len = $urandom_range(45, 60);
      else len = $urandom_range(1, 8);
      repeat (len) put_char(random_cp());
    end else begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        if ($urandom_range(0, 1) != 0) str_bytes.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
        else str_bytes.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    n = str_bytes.size();
    commit_string($urandom_range(0, 7) == 0,
                  ($urandom_range(0, 11) == 0) ? $urandom_range(0, n - 1) : -1);
  endtask

  task automatic run_random(int n_bytes);
    int total;
    int n;
    total = 0;
    gen_string(cvt_en, n);
    total += n;
    while (total < n_bytes) begin
      gen_string(1'b0, n);
      total += n;
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_convert(bit on);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cvt_en = on;
    @(posedge clk);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_convert(1'b1);
    str_bytes = '{8'h41};
    commit_string(1'b0, -1);
    // A zero byte is data, not the end of the string.
    str_bytes = '{8'h00, 8'h7F};
    commit_string(1'b0, -1);
    str_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hA7, 8'hE2, 8'h8C, 8'h90};
    commit_string(1'b1, 3);
    str_bytes = '{8'hE2, 8'h96, 8'hA0, 8'hC2, 8'hA0, 8'hC3, 8'h87};
    commit_string(1'b0, -1);
    // A continuation byte that opens a string is taken as a lead byte.
    str_bytes = '{8'h80, 8'hBF};
    commit_string(1'b0, -1);
    str_bytes = '{8'hFF};
    commit_string(1'b0, -1);
    run_random(200);

    set_convert(1'b0);
    str_bytes = '{8'h00, 8'hFF, 8'hC3, 8'hA9};
    commit_string(1'b0, -1);
    run_random(100);

    set_convert(1'b1);
    run_random(160);

    wait_drained();
    if (n_err == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/u2c_pkg.sv
rtl/core/u2c_ifs.sv
rtl/core/u2c_decode.sv
rtl/core/u2c_outbuf.sv
rtl/core/utf8_to_cp437_converter_top.sv
sim/testbench.sv
